// ----- src/sblc_pkg.sv -----
package sblc_pkg;

    localparam int ENTRIES_DEF   = 32;
    localparam int ID_W          = 6;            // wide enough for any legal ENTRIES
    localparam logic [31:0] LIMIT_FLOOR   = 32'd1000000;
    localparam logic [31:0] LIMIT_RESET   = 32'd8388608;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_ACCESS = 2'd2;
    localparam logic [1:0] OP_RESIZE = 2'd3;

    localparam logic [1:0] KIND_SWAP   = 2'd0;
    localparam logic [1:0] KIND_RELOAD = 2'd1;
    localparam logic [1:0] KIND_DONE   = 2'd2;
    localparam logic [1:0] KIND_NOROOM = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [4:0]  entry_id;
        logic [31:0] item_size;
        logic [31:0] data_tag;
    } req_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [4:0]  out_id;
        logic [31:0] out_tag;
        logic [31:0] used_total;
        logic        last;
    } rsp_t;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_ADD,
        CMD_CLEAR,
        CMD_EVICT,
        CMD_LIST,
        CMD_PLACE,
        CMD_UNSWAP
    } cmd_code_t;

    typedef struct packed {
        cmd_code_t       code;
        logic [ID_W-1:0] idx;
        logic [ID_W-1:0] rank;
        logic [31:0]     bytes;
        logic [31:0]     tag;
    } cmd_t;

    typedef struct packed {
        logic            found;
        logic [ID_W-1:0] rank;
        logic [ID_W-1:0] id;
    } cand_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_EVAL,
        S_SEARCH,
        S_EVICT,
        S_FINAL
    } state_t;

endpackage

// ----- src/sblc_cell.sv -----
module sblc_cell #(
    parameter int INDEX = 0,
    parameter int IW    = 5
) (
    input  logic                clk,
    input  logic                rst_n,
    input  sblc_pkg::cmd_t      cmd,
    input  sblc_pkg::cand_t     cand_in,
    output sblc_pkg::cand_t     cand_out,
    output logic [31:0]         bytes,
    output logic [31:0]         tag,
    output logic                listed,
    output logic                swapped,
    output logic [IW-1:0]       rank
);
    import sblc_pkg::*;

    logic [31:0]   bytes_reg, tag_reg;
    logic          listed_reg, swapped_reg;
    logic [IW-1:0] rank_reg;
    cand_t         cand_reg, cand_next;
    logic          hit, better;

    assign hit = (cmd.idx == ID_W'(INDEX));

    always_comb
    begin
        better = listed_reg && (!cand_in.found || (ID_W'(rank_reg) > cand_in.rank));
        if (better)
        begin
            cand_next.found = 1'b1;
            cand_next.rank  = ID_W'(rank_reg);
            cand_next.id    = ID_W'(INDEX);
        end
        else
        begin
            cand_next = cand_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_reg   <= '0;
            tag_reg     <= '0;
            listed_reg  <= 1'b0;
            swapped_reg <= 1'b0;
            rank_reg    <= IW'(INDEX);
            cand_reg    <= '0;
        end
        else
        begin
            cand_reg <= cand_next;
            case (cmd.code)
                CMD_ADD:
                begin
                    if (hit)
                    begin
                        bytes_reg   <= cmd.bytes;
                        tag_reg     <= cmd.tag;
                        listed_reg  <= 1'b0;
                        swapped_reg <= 1'b0;
                    end
                end
                CMD_CLEAR:
                begin
                    if (hit)
                    begin
                        bytes_reg  <= '0;
                        tag_reg    <= '0;
                        listed_reg <= 1'b0;
                    end
                end
                CMD_EVICT:
                begin
                    if (hit)
                    begin
                        listed_reg  <= 1'b0;
                        swapped_reg <= 1'b1;
                    end
                end
                CMD_LIST, CMD_PLACE:
                begin
                    if (hit)
                    begin
                        rank_reg <= '0;
                        if (cmd.code == CMD_LIST)
                        begin
                            listed_reg  <= 1'b1;
                            swapped_reg <= 1'b0;
                        end
                    end
                    else if (ID_W'(rank_reg) < cmd.rank)
                    begin
                        rank_reg <= rank_reg + 1'b1;
                    end
                end
                CMD_UNSWAP:
                begin
                    if (hit)
                        swapped_reg <= 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign cand_out = cand_reg;
    assign bytes    = bytes_reg;
    assign tag      = tag_reg;
    assign listed   = listed_reg;
    assign swapped  = swapped_reg;
    assign rank     = rank_reg;

endmodule

// ----- src/size_budget_lru_cache.sv -----
// Byte-budget LRU cache controller. Requests are taken one at a time, only while the
// controller is idle. After the idle state accepts it, a request passes through decode,
// the fit test when it may need room (add with a new size or tag, access of a swapped
// entry, resize to a limit of at least LIMIT_FLOOR), and the final state that issues the
// result. Each evicted entry adds a victim search, which ripples the least-recent
// candidate down the row of entry cells, one cell per cycle, and an evict step that
// issues the swap-out before the fit test runs again. Output stalls hold the evict and
// final steps. A configuration write loads the working limit at once without evicting.
module size_budget_lru_cache #(
    parameter int ENTRIES = sblc_pkg::ENTRIES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  sblc_pkg::req_t in_data,
    output logic           out_valid,
    input  logic           out_stall,
    output sblc_pkg::rsp_t out_data,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [31:0]    cfg_data
);
    import sblc_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    state_t      state_reg, state_next;
    logic [31:0] resident_reg, resident_next;
    logic [31:0] limit_reg, limit_next;
    logic [31:0] need_reg, need_next;
    req_t        req_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [1:0]  fin_kind_reg, fin_kind_next;
    logic [4:0]  fin_id_reg, fin_id_next;
    logic [31:0] fin_tag_reg, fin_tag_next;
    logic [31:0] fail_tag_reg, fail_tag_next;
    cmd_code_t   act_reg, act_next;
    logic        out_valid_reg, out_valid_next;
    rsp_t        out_reg, out_next;

    cmd_t        cmd;
    cand_t       chain [ENTRIES+1];
    logic [31:0] c_bytes [ENTRIES];
    logic [31:0] c_tag   [ENTRIES];
    logic        c_listed  [ENTRIES];
    logic        c_swapped [ENTRIES];
    logic [IW-1:0] c_rank  [ENTRIES];

    logic [IW-1:0] req_idx, rd_idx, victim_idx;
    logic        in_range, out_free, fits;
    logic [31:0] rd_bytes, rd_tag;
    logic        rd_listed, rd_swapped;
    logic [IW-1:0] rd_rank;

    assign chain[0] = '0;

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        sblc_cell #(.INDEX(i), .IW(IW)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cmd      (cmd),
            .cand_in  (chain[i]),
            .cand_out (chain[i+1]),
            .bytes    (c_bytes[i]),
            .tag      (c_tag[i]),
            .listed   (c_listed[i]),
            .swapped  (c_swapped[i]),
            .rank     (c_rank[i])
        );
    end

    assign req_idx    = IW'(req_reg.entry_id);
    assign in_range   = (32'(req_reg.entry_id) < 32'(ENTRIES));
    assign victim_idx = IW'(chain[ENTRIES].id);
    assign rd_idx     = (state_reg == S_EVICT) ? victim_idx : req_idx;
    assign rd_bytes   = c_bytes[rd_idx];
    assign rd_tag     = c_tag[rd_idx];
    assign rd_listed  = c_listed[rd_idx];
    assign rd_swapped = c_swapped[rd_idx];
    assign rd_rank    = c_rank[rd_idx];

    assign out_free = !out_valid_reg || !out_stall;
    assign fits     = ({1'b0, resident_reg} + {1'b0, need_reg}) <= {1'b0, limit_reg};
    assign in_stall = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    function automatic logic [31:0] sat_sub(input logic [31:0] a, input logic [31:0] b);
        sat_sub = (b > a) ? 32'd0 : a - b;
    endfunction

    always_comb
    begin
        state_next     = state_reg;
        resident_next  = resident_reg;
        limit_next     = limit_reg;
        need_next      = need_reg;
        cnt_next       = cnt_reg;
        fin_kind_next  = fin_kind_reg;
        fin_id_next    = fin_id_reg;
        fin_tag_next   = fin_tag_reg;
        fail_tag_next  = fail_tag_reg;
        act_next       = act_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_next       = out_reg;
        cmd.code       = CMD_NONE;
        cmd.idx        = ID_W'(rd_idx);
        cmd.rank       = ID_W'(rd_rank);
        cmd.bytes      = req_reg.item_size;
        cmd.tag        = req_reg.data_tag;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_DECODE;
            end
            S_DECODE:
            begin
                fin_kind_next = KIND_DONE;
                fin_id_next   = req_reg.entry_id;
                fin_tag_next  = '0;
                fail_tag_next = '0;
                act_next      = CMD_NONE;
                need_next     = '0;
                state_next    = S_FINAL;
                if (req_reg.op == OP_RESIZE)
                begin
                    fin_id_next = '0;
                    if (req_reg.item_size >= LIMIT_FLOOR)
                    begin
                        limit_next = req_reg.item_size;
                        state_next = S_EVAL;
                    end
                end
                else if (!in_range)
                begin
                end
                else
                begin
                    case (req_reg.op)
                        OP_ADD:
                        begin
                            if (rd_bytes != req_reg.item_size || rd_tag != req_reg.data_tag)
                            begin
                                cmd.code = CMD_ADD;
                                if (rd_listed)
                                    resident_next = sat_sub(resident_reg, rd_bytes);
                                need_next     = req_reg.item_size;
                                fin_tag_next  = req_reg.data_tag;
                                fail_tag_next = req_reg.data_tag;
                                act_next      = CMD_LIST;
                                state_next    = S_EVAL;
                            end
                            else
                            begin
                                fin_tag_next = rd_tag;
                            end
                        end
                        OP_REMOVE:
                        begin
                            act_next = CMD_CLEAR;
                        end
                        default:
                        begin
                            fin_tag_next = rd_tag;
                            if (rd_swapped)
                            begin
                                need_next     = rd_bytes;
                                fin_kind_next = KIND_RELOAD;
                                fail_tag_next = rd_tag;
                                act_next      = rd_listed ? CMD_UNSWAP : CMD_LIST;
                                state_next    = S_EVAL;
                            end
                            else if (rd_listed)
                            begin
                                act_next = CMD_PLACE;
                            end
                        end
                    endcase
                end
            end
            S_EVAL:
            begin
                cnt_next = '0;
                state_next = fits ? S_FINAL : S_SEARCH;
            end
            S_SEARCH:
            begin
                // wait for the candidate to ripple through every cell
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(ENTRIES - 1))
                    state_next = S_EVICT;
            end
            S_EVICT:
            begin
                if (!chain[ENTRIES].found)
                begin
                    fin_kind_next = KIND_NOROOM;
                    fin_id_next   = req_reg.entry_id;
                    fin_tag_next  = fail_tag_reg;
                    act_next      = CMD_NONE;
                    state_next    = S_FINAL;
                end
                else if (out_free)
                begin
                    cmd.code       = CMD_EVICT;
                    resident_next  = sat_sub(resident_reg, rd_bytes);
                    out_valid_next = 1'b1;
                    out_next.kind       = KIND_SWAP;
                    out_next.out_id     = 5'(victim_idx);
                    out_next.out_tag    = rd_tag;
                    out_next.used_total = resident_next;
                    out_next.last       = 1'b0;
                    state_next     = S_EVAL;
                end
            end
            S_FINAL:
            begin
                if (out_free)
                begin
                    cmd.code = act_reg;
                    if (act_reg == CMD_LIST)
                        resident_next = resident_reg + rd_bytes;
                    else if (act_reg == CMD_CLEAR && rd_listed)
                        resident_next = sat_sub(resident_reg, rd_bytes);
                    out_valid_next = 1'b1;
                    out_next.kind       = fin_kind_reg;
                    out_next.out_id     = fin_id_reg;
                    out_next.out_tag    = fin_tag_reg;
                    out_next.used_total = resident_next;
                    out_next.last       = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_valid && cfg_ready)
            limit_next = cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            resident_reg  <= '0;
            limit_reg     <= LIMIT_RESET;
            cnt_reg       <= '0;
            act_reg       <= CMD_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            resident_reg  <= resident_next;
            limit_reg     <= limit_next;
            cnt_reg       <= cnt_next;
            act_reg       <= act_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
            req_reg <= in_data;
        need_reg     <= need_next;
        fin_kind_reg <= fin_kind_next;
        fin_id_reg   <= fin_id_next;
        fin_tag_reg  <= fin_tag_next;
        fail_tag_reg <= fail_tag_next;
        out_reg      <= out_next;
    end

endmodule

// ----- src/sblc_check.sv -----
module sblc_check (
    input logic           clk,
    input logic           rst_n,
    input logic           in_valid,
    input logic           in_stall,
    input logic           out_valid,
    input logic           out_stall,
    input sblc_pkg::rsp_t out_data
);
    import sblc_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second request taken while one is open");

    a_swap_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.kind == KIND_SWAP |-> !out_data.last)
        else $error("swap-out marked as final result");

    a_final_kinds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.kind == KIND_RELOAD || out_data.kind == KIND_DONE
                      || out_data.kind == KIND_NOROOM) |-> out_data.last)
        else $error("final kind without last");

endmodule

bind size_budget_lru_cache sblc_check u_sblc_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
